FILE: sv/bitmap_extent_block_allocator_unit_assert.svh
// Assertion macros shared by the allocator checker.
`ifndef BITMAP_EXTENT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_EXTENT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BXA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BXA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

FILE: sv/bxa_pkg.sv
// Shared types and constants of the bitmap extent block allocator.
package bxa_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int LEN_W      = 7;
  localparam int MAX_REQ    = 64;
  localparam int BLK_SHIFT  = 9;

  localparam logic [1:0] KIND_ALLOC_CF = 2'd0;
  localparam logic [1:0] KIND_ALLOC_SC = 2'd1;
  localparam logic [1:0] KIND_FREE     = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] byte_size;
    logic [7:0]  free_start;
    logic [8:0]  free_len;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       extent_start;
    logic [LEN_W-1:0] extent_len;
    logic             last;
    logic [CNT_W-1:0] free_count;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic             val;
  } map_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_RUN, S_MARK, S_SCAT, S_FREE, S_RESP
  } state_t;

endpackage

FILE: sv/bitmap_extent_block_allocator_unit.sv
// Top level of the bitmap extent block allocator; one request is in flight at a time.
// Reset is synchronous, sets the free count to 256 and clears the map while stalling the input.
// A rejected request is answered with a single last transfer from the response state.
// Contiguous-first searches for a free run, marks it and answers with one transfer;
// scattered takes free blocks in map order and gives one transfer per extent, the last flagged;
// a failed contiguous search falls back to the scattered walk, and output stalls hold a transfer.
module bitmap_extent_block_allocator_unit import bxa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  map_cmd_t         map_cmd;
  logic [IDX_W-1:0] map_idx;
  logic             map_used;
  logic             map_busy;

  bxa_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (map_cmd),
    .rd_idx  (map_idx),
    .rd_used (map_used),
    .busy    (map_busy)
  );

  bxa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .map_cmd   (map_cmd),
    .map_idx   (map_idx),
    .map_used  (map_used),
    .map_busy  (map_busy)
  );

endmodule

FILE: sv/bxa_map.sv
// Used-block map with one bit per block, a single read and a single write port.
module bxa_map import bxa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  map_cmd_t         cmd,
  input  logic [IDX_W-1:0] rd_idx,
  output logic             rd_used,
  output logic             busy
);

  logic             used_r [NUM_BLOCKS];
  logic [CNT_W-1:0] clr_r;
  logic             rd_used_r;
  logic             clearing;

  assign clearing = !clr_r[IDX_W];
  assign busy     = clearing;
  assign rd_used  = rd_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (clearing) begin
      clr_r <= clr_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      used_r[clr_r[IDX_W-1:0]] <= 1'b0;
    end else if (cmd.we) begin
      used_r[cmd.idx] <= cmd.val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.we && cmd.idx == rd_idx) begin
      rd_used_r <= cmd.val;
    end else begin
      rd_used_r <= used_r[rd_idx];
    end
  end

endmodule

FILE: sv/bxa_seq.sv
// Request sequencer that walks the used map one block per cycle while its output is not stalled.
module bxa_seq import bxa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  output map_cmd_t         map_cmd,
  output logic [IDX_W-1:0] map_idx,
  input  logic             map_used,
  input  logic             map_busy
);

  state_t           state_r, state_nxt;
  in_t              req_r, req_nxt;
  logic [LEN_W-1:0] need_r, need_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;
  logic [CNT_W-1:0] fc_r, fc_nxt;
  logic [LEN_W-1:0] run_r, run_nxt;
  logic [IDX_W-1:0] rstart_r, rstart_nxt;
  logic [LEN_W-1:0] got_r, got_nxt;
  logic             open_r, open_nxt;
  logic [IDX_W-1:0] cstart_r, cstart_nxt;
  logic [LEN_W-1:0] clen_r, clen_nxt;
  logic [1:0]       rstat_r, rstat_nxt;
  logic [IDX_W-1:0] rs_r, rs_nxt;
  logic [LEN_W-1:0] rl_r, rl_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic [7:0]       need8;
  logic             bad_size;
  logic [9:0]       end10;
  logic             out_free;
  logic             bit_free;
  logic             run_hit;
  logic [IDX_W-1:0] run_st;
  logic             scat_last;
  logic             scat_emit;
  logic             take;

  assign need8     = 8'(({1'b0, req_r.byte_size} + 17'd511) >> BLK_SHIFT);
  assign bad_size  = (need8 == 8'd0) || (need8 > 8'(MAX_REQ));
  assign end10     = 10'(req_r.free_start) + 10'(req_r.free_len);
  assign out_free  = !out_valid_r || !out_stall;
  assign bit_free  = !map_used;
  assign run_hit   = bit_free && ((run_r + 7'd1) == need_r);
  assign run_st    = (run_r == '0) ? i_r[IDX_W-1:0] : rstart_r;
  assign scat_last = bit_free && ((got_r + 7'd1) == need_r);
  assign scat_emit = scat_last || (!bit_free && open_r);
  assign map_idx   = i_nxt[IDX_W-1:0];
  assign in_stall  = (state_r != S_IDLE) || map_busy;
  assign take      = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (take) state_nxt = S_DEC;
      S_DEC: begin
        priority if (req_r.kind == KIND_ALLOC_CF || req_r.kind == KIND_ALLOC_SC) begin
          if (bad_size || fc_r < {1'b0, need8}) state_nxt = S_RESP;
          else if (req_r.kind == KIND_ALLOC_CF) state_nxt = S_RUN;
          else state_nxt = S_SCAT;
        end else if (req_r.kind == KIND_FREE) begin
          state_nxt = (end10 > 10'(NUM_BLOCKS)) ? S_RESP : S_FREE;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RUN: begin
        if (run_hit) state_nxt = S_MARK;
        else if (i_r == 9'(NUM_BLOCKS - 1)) state_nxt = S_SCAT;
      end
      S_MARK: if ((got_r + 7'd1) == need_r) state_nxt = S_RESP;
      S_SCAT: if (scat_last && out_free) state_nxt = S_IDLE;
      S_FREE: if (i_r == end_r) state_nxt = S_RESP;
      S_RESP: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    req_nxt       = req_r;
    need_nxt      = need_r;
    i_nxt         = i_r;
    end_nxt       = end_r;
    fc_nxt        = fc_r;
    run_nxt       = run_r;
    rstart_nxt    = rstart_r;
    got_nxt       = got_r;
    open_nxt      = open_r;
    cstart_nxt    = cstart_r;
    clen_nxt      = clen_r;
    rstat_nxt     = rstat_r;
    rs_nxt        = rs_r;
    rl_nxt        = rl_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    map_cmd       = '{we: 1'b0, idx: i_r[IDX_W-1:0], val: 1'b1};
    unique case (state_r)
      S_IDLE: if (take) req_nxt = in_data;
      S_DEC: begin
        rstat_nxt = ST_BAD;
        rs_nxt    = '0;
        rl_nxt    = '0;
        i_nxt     = '0;
        run_nxt   = '0;
        got_nxt   = '0;
        open_nxt  = 1'b0;
        need_nxt  = need8[LEN_W-1:0];
        priority if (req_r.kind == KIND_ALLOC_CF || req_r.kind == KIND_ALLOC_SC) begin
          if (!bad_size) begin
            if (fc_r < {1'b0, need8}) rstat_nxt = ST_NOSPACE;
            else fc_nxt = fc_r - 9'(need8);
          end
        end else if (req_r.kind == KIND_FREE) begin
          i_nxt   = 9'(req_r.free_start);
          end_nxt = end10[CNT_W-1:0];
          if (end10 <= 10'(NUM_BLOCKS)) rstat_nxt = ST_OK;
        end else begin
          rstat_nxt = ST_BAD;
        end
      end
      S_RUN: begin
        if (bit_free) begin
          rstart_nxt = run_st;
          run_nxt    = run_r + 7'd1;
        end else begin
          run_nxt = '0;
        end
        if (run_hit) i_nxt = 9'(run_st);
        else if (i_r == 9'(NUM_BLOCKS - 1)) i_nxt = '0;
        else i_nxt = i_r + 9'd1;
      end
      S_MARK: begin
        map_cmd.we = 1'b1;
        got_nxt    = got_r + 7'd1;
        i_nxt      = i_r + 9'd1;
        rstat_nxt  = ST_OK;
        rs_nxt     = rstart_r;
        rl_nxt     = need_r;
      end
      S_SCAT: begin
        if (scat_emit) begin
          if (out_free) begin
            out_valid_nxt        = 1'b1;
            out_nxt.status       = ST_OK;
            out_nxt.last         = scat_last;
            out_nxt.free_count   = fc_r;
            if (scat_last) begin
              map_cmd.we           = 1'b1;
              out_nxt.extent_start = open_r ? cstart_r : i_r[IDX_W-1:0];
              out_nxt.extent_len   = open_r ? clen_r + 7'd1 : 7'd1;
            end else begin
              out_nxt.extent_start = cstart_r;
              out_nxt.extent_len   = clen_r;
              open_nxt             = 1'b0;
              i_nxt                = i_r + 9'd1;
            end
          end
        end else begin
          i_nxt = i_r + 9'd1;
          if (bit_free) begin
            map_cmd.we = 1'b1;
            got_nxt    = got_r + 7'd1;
            if (open_r) begin
              clen_nxt = clen_r + 7'd1;
            end else begin
              open_nxt   = 1'b1;
              cstart_nxt = i_r[IDX_W-1:0];
              clen_nxt   = 7'd1;
            end
          end
        end
      end
      S_FREE: begin
        if (i_r != end_r) begin
          i_nxt = i_r + 9'd1;
          if (!bit_free) begin
            map_cmd.we  = 1'b1;
            map_cmd.val = 1'b0;
            fc_nxt      = fc_r + 9'd1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: rstat_r, extent_start: rs_r, extent_len: rl_r,
                            last: 1'b1, free_count: fc_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fc_r        <= 9'(NUM_BLOCKS);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fc_r        <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    need_r   <= need_nxt;
    i_r      <= i_nxt;
    end_r    <= end_nxt;
    run_r    <= run_nxt;
    rstart_r <= rstart_nxt;
    got_r    <= got_nxt;
    open_r   <= open_nxt;
    cstart_r <= cstart_nxt;
    clen_r   <= clen_nxt;
    rstat_r  <= rstat_nxt;
    rs_r     <= rs_nxt;
    rl_r     <= rl_nxt;
    out_r    <= out_nxt;
  end

endmodule

FILE: sv/bxa_checker.sv
// Port-level checker for the allocator, bound to the top level.
`include "bitmap_extent_block_allocator_unit_assert.svh"
module bxa_checker import bxa_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `BXA_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  `BXA_ASSERT_SAME(a_reject_is_last, out_valid && out_data.status != ST_OK, out_data.last)
  `BXA_ASSERT_SAME(a_reject_no_extent, out_valid && out_data.status != ST_OK, out_data.extent_len == '0)
  `BXA_ASSERT_SAME(a_count_range, out_valid, out_data.free_count <= 9'(NUM_BLOCKS))
  `BXA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind bitmap_extent_block_allocator_unit bxa_checker u_bxa_checker (.*);
